// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Check a property on rising edges outside reset.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== rtl/irpwd_pkg.sv =====
// Shared types and constants of the infrared pulse-width frame decoder.
package irpwd_pkg;

  // Command codes carried in the input tuser bit
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Bit position codes
  localparam logic [5:0] POS_IDLE    = 6'd0;
  localparam logic [5:0] POS_FIRST   = 6'd1;
  localparam logic [5:0] FRAME_BITS  = 6'd32;
  localparam logic [5:0] FRAME_DONE  = 6'd33;
  localparam logic [5:0] REPEAT_MARK = 6'd40;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_START_WIDTH        = 3'd0,
    REG_REPEAT_START_WIDTH = 3'd1,
    REG_REPEAT_END_WIDTH   = 3'd2,
    REG_ONE_WIDTH          = 3'd3,
    REG_ZERO_WIDTH         = 3'd4,
    REG_TOLERANCE          = 3'd5,
    REG_CHECK_MASK         = 3'd6,
    REG_REPORT_REPEAT      = 3'd7
  } reg_idx_t;

  // Register reset values
  localparam logic [15:0] RST_START_WIDTH        = 16'd4500;
  localparam logic [15:0] RST_REPEAT_START_WIDTH = 16'd2250;
  localparam logic [15:0] RST_REPEAT_END_WIDTH   = 16'd0;
  localparam logic [15:0] RST_ONE_WIDTH          = 16'd1690;
  localparam logic [15:0] RST_ZERO_WIDTH         = 16'd560;
  localparam logic [15:0] RST_TOLERANCE          = 16'd200;
  localparam logic [1:0]  RST_CHECK_MASK         = 2'd3;
  localparam logic        RST_REPORT_REPEAT      = 1'b1;

  typedef struct packed {
    logic [15:0] start_width;
    logic [15:0] repeat_start_width;
    logic [15:0] repeat_end_width;
    logic [15:0] one_width;
    logic [15:0] zero_width;
    logic [15:0] tolerance;
    logic [1:0]  check_mask;
    logic        report_repeat;
  } cfg_t;

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] frame_word;
  } res_t;

endpackage

// ===== rtl/irpwd_window.sv =====
// Tolerance window compare of one measured width against one nominal width.
module irpwd_window (
  input  logic [15:0] width,
  input  logic [15:0] nominal,
  input  logic [15:0] tolerance,
  output logic        hit
);
  logic [15:0] lo;
  logic [16:0] hi;

  // Clamp the lower bound at zero, keep the carry on the upper bound
  assign lo  = (nominal > tolerance) ? (nominal - tolerance) : 16'd0;
  assign hi  = {1'b0, nominal} + {1'b0, tolerance};
  assign hit = (width >= lo) && ({1'b0, width} <= hi);
endmodule

// ===== rtl/irpwd_core.sv =====
// Frame state of the decoder: edge phase, bit collection, frame word and ready flag.
module irpwd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           cmd,
  input  logic [15:0]    capture,
  input  irpwd_pkg::cfg_t cfg,
  output irpwd_pkg::res_t res
);
  import irpwd_pkg::*;

  logic        phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic        ready_r, ready_nxt;

  logic        hit_start, hit_rstart, hit_rend, hit_one, hit_zero;
  logic        collecting;
  logic [5:0]  bit_off;
  logic [31:0] word_set;
  logic        bad_addr, bad_cmd;

  irpwd_window u_win_start (
    .width(capture), .nominal(cfg.start_width), .tolerance(cfg.tolerance), .hit(hit_start)
  );
  irpwd_window u_win_rstart (
    .width(capture), .nominal(cfg.repeat_start_width), .tolerance(cfg.tolerance),
    .hit(hit_rstart)
  );
  irpwd_window u_win_rend (
    .width(capture), .nominal(cfg.repeat_end_width), .tolerance(cfg.tolerance),
    .hit(hit_rend)
  );
  irpwd_window u_win_one (
    .width(capture), .nominal(cfg.one_width), .tolerance(cfg.tolerance), .hit(hit_one)
  );
  irpwd_window u_win_zero (
    .width(capture), .nominal(cfg.zero_width), .tolerance(cfg.tolerance), .hit(hit_zero)
  );

  assign collecting = (pos_r >= POS_FIRST) && (pos_r <= FRAME_BITS);
  // MSB-first: position 1 lands in bit 31, position 32 in bit 0
  assign bit_off    = FRAME_BITS - pos_r;
  assign word_set   = word_r | (hit_one ? (32'h1 << bit_off[4:0]) : 32'h0);
  assign bad_addr   = cfg.check_mask[0] && (word_set[31:24] != ~word_set[23:16]);
  assign bad_cmd    = cfg.check_mask[1] && (word_set[15:8] != ~word_set[7:0]);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    word_nxt  = word_r;
    ready_nxt = ready_r;
    res       = '0;
    if (fire) begin
      if (cmd == CMD_READ) begin
        if (ready_r) begin
          ready_nxt       = 1'b0;
          res.frame_valid = 1'b1;
          res.frame_word  = word_r;
        end
      end else if (phase_r) begin
        phase_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
        if (hit_start) begin
          pos_nxt  = POS_FIRST;
          word_nxt = '0;
        end else if (hit_rstart) begin
          pos_nxt = REPEAT_MARK;
        end else if (collecting) begin
          if (hit_one || hit_zero) begin
            word_nxt = word_set;
            pos_nxt  = pos_r + 6'd1;
            if ((pos_nxt == FRAME_DONE) && !bad_addr && !bad_cmd) begin
              ready_nxt = 1'b1;
            end
          end else begin
            pos_nxt = POS_IDLE;   // abort, keep the bits collected so far
          end
        end else if ((pos_r == REPEAT_MARK) && hit_rend && cfg.report_repeat) begin
          ready_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b1;
      pos_r   <= POS_IDLE;
      word_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      word_r  <= word_nxt;
      ready_r <= ready_nxt;
    end
  end
endmodule

// ===== rtl/ir_pulse_width_frame_decoder.sv =====
// Top level of the infrared pulse-width frame decoder: ports, registers, pipeline.
//
//   channel  | direction | transaction contents
//   ---------+-----------+-----------------------------------------------------
//   in_      | sink      | tuser = command, tdata = capture_value
//   out_     | source    | tuser = frame_valid, tdata = frame_word
//   cfg_     | APB slave | eight registers at byte addresses 0x00..0x1C
//
// Every transaction passes through the input register and then the result
// register; a new one is taken every cycle while the result side keeps up.
// The frame state update (window compares, bit insert, inverse checks) sits
// between these two registers and sets that rate.
// Reset is synchronous: both stages empty, frame state cleared, registers at defaults.
// A stall on out_tready holds the result; the input register still fills once,
// then in_tready drops until the result moves on.
module ir_pulse_width_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] capture_value
  input  logic        in_tuser,    // [0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] frame_word
  output logic        out_tuser,   // [0] frame_valid
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import irpwd_pkg::*;

  // input register
  logic        in_valid_r, in_valid_nxt;
  logic        in_cmd_r;
  logic [15:0] in_cap_r;
  // result register
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;
  res_t        core_res;
  // configuration
  cfg_t        cfg_r, cfg_nxt;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  logic        out_can;
  logic        fire;
  logic        in_accept;

  // Advance when the result register is empty or being drained this cycle
  assign out_can   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_can;
  assign in_tready = !in_valid_r || out_can;
  assign in_accept = in_tvalid && in_tready;

  assign in_valid_nxt  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load input on accept, result on fire
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_cmd_r <= in_tuser;
      in_cap_r <= in_tdata;
    end
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  irpwd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .cmd    (in_cmd_r),
    .capture(in_cap_r),
    .cfg    (cfg_r),
    .res    (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.frame_valid;
  assign out_tdata  = out_res_r.frame_word;

  // Configuration registers, written on the access phase of an APB write
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_WIDTH:        cfg_nxt.start_width        = cfg_pwdata[15:0];
        REG_REPEAT_START_WIDTH: cfg_nxt.repeat_start_width = cfg_pwdata[15:0];
        REG_REPEAT_END_WIDTH:   cfg_nxt.repeat_end_width   = cfg_pwdata[15:0];
        REG_ONE_WIDTH:          cfg_nxt.one_width          = cfg_pwdata[15:0];
        REG_ZERO_WIDTH:         cfg_nxt.zero_width         = cfg_pwdata[15:0];
        REG_TOLERANCE:          cfg_nxt.tolerance          = cfg_pwdata[15:0];
        REG_CHECK_MASK:         cfg_nxt.check_mask         = cfg_pwdata[1:0];
        REG_REPORT_REPEAT:      cfg_nxt.report_repeat      = cfg_pwdata[0];
        default:                cfg_nxt                    = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START_WIDTH:        cfg_prdata = {16'd0, cfg_r.start_width};
      REG_REPEAT_START_WIDTH: cfg_prdata = {16'd0, cfg_r.repeat_start_width};
      REG_REPEAT_END_WIDTH:   cfg_prdata = {16'd0, cfg_r.repeat_end_width};
      REG_ONE_WIDTH:          cfg_prdata = {16'd0, cfg_r.one_width};
      REG_ZERO_WIDTH:         cfg_prdata = {16'd0, cfg_r.zero_width};
      REG_TOLERANCE:          cfg_prdata = {16'd0, cfg_r.tolerance};
      REG_CHECK_MASK:         cfg_prdata = {30'd0, cfg_r.check_mask};
      REG_REPORT_REPEAT:      cfg_prdata = {31'd0, cfg_r.report_repeat};
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_width        <= RST_START_WIDTH;
      cfg_r.repeat_start_width <= RST_REPEAT_START_WIDTH;
      cfg_r.repeat_end_width   <= RST_REPEAT_END_WIDTH;
      cfg_r.one_width          <= RST_ONE_WIDTH;
      cfg_r.zero_width         <= RST_ZERO_WIDTH;
      cfg_r.tolerance          <= RST_TOLERANCE;
      cfg_r.check_mask         <= RST_CHECK_MASK;
      cfg_r.report_repeat      <= RST_REPORT_REPEAT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

// ===== rtl/irpwd_checker.sv =====
// Port-level checker of the decoder and its bind to the top level.
`include "assert_macros.svh"

module irpwd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  // result register is empty right after reset
  `ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  // a draining result side always frees the input register
  `ASSERT_ALWAYS(a_ready_follows, clk, out_tready |-> in_tready, "input stalled while output drains")
  // a result without a frame carries a zero word
  `ASSERT_RUN(a_zero_word, clk, rst_n, (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0), "nonzero word without frame")
  // a stalled result holds
  `ASSERT_RUN(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")
endmodule

bind ir_pulse_width_frame_decoder irpwd_checker u_irpwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
